// ===== src/iou_pkg.sv =====
package iou_pkg;

  localparam int MAX_TRACKS_DEF = 16;
  localparam int COORD_BITS_DEF = 12;
  localparam int BOX_COORD_W    = 12;
  localparam int BOX_SIZE_W     = 11;
  localparam int ID_W           = 8;
  localparam int THR_W          = 8;
  localparam logic [THR_W-1:0] THR_RESET = 8'd128;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_box;    // capture the input beat
    logic scan_read;   // present read address for a previous-table entry
    logic scan_eval;   // evaluate returned entry against the box
    logic decide;      // choose matched or new id
    logic find_read;   // present read address for a current-table entry
    logic find_eval;   // compare returned entry id
    logic commit;      // write box and form the result
    logic close_only;  // form an empty result
    logic swap;        // swap banks at frame end
  } iou_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_last;
    logic find_last;
    logic find_hit;
  } iou_sts_t;

endpackage

// ===== src/iou_ram.sv =====
module iou_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/iou_ctrl.sv =====
module iou_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              box_valid,
  output logic              box_ready,
  input  logic              no_detection,
  input  logic              frame_last,
  output logic              out_valid,
  input  logic              out_ready,
  input  iou_pkg::iou_sts_t sts,
  output iou_pkg::iou_cmd_t cmd
);
  import iou_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_DEC   = 3'd2;
  localparam logic [2:0] S_FIND  = 3'd3;
  localparam logic [2:0] S_COMM  = 3'd4;
  localparam logic [2:0] S_SMUL  = 3'd5;
  localparam logic [2:0] S_SEVAL = 3'd6;
  localparam logic [2:0] S_FEVAL = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       last;
  logic       out_valid_next;

  // A new beat is taken once the prior result has left the output register.
  assign box_ready = (state == S_IDLE) && !out_valid;

  always_comb begin
    cmd        = '0;
    state_next = state;
    out_valid_next = out_valid && !out_ready;
    case (state)
      S_IDLE: begin
        if (box_valid && box_ready) begin
          cmd.load_box = 1'b1;
          if (no_detection) begin
            cmd.close_only = 1'b1;
            cmd.swap       = frame_last;
            out_valid_next = 1'b1;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd.scan_read = 1'b1;
        state_next    = S_SMUL;
      end
      // The entry is on the read port; its products are registered.
      S_SMUL: begin
        state_next = S_SEVAL;
      end
      S_SEVAL: begin
        cmd.scan_eval = 1'b1;
        state_next    = sts.scan_last ? S_DEC : S_SCAN;
      end
      S_DEC: begin
        cmd.decide = 1'b1;
        state_next = S_FIND;
      end
      S_FIND: begin
        cmd.find_read = 1'b1;
        state_next    = S_FEVAL;
      end
      S_FEVAL: begin
        cmd.find_eval = 1'b1;
        state_next    = (sts.find_hit || sts.find_last) ? S_COMM : S_FIND;
      end
      S_COMM: begin
        cmd.commit = 1'b1;
        cmd.swap   = last;
        out_valid_next = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      last      <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      if (cmd.load_box) begin
        last <= frame_last;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid)
    else $error("result not raised after commit");
  assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !box_ready)
    else $error("ready while busy");
  assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.scan_read, cmd.scan_eval, cmd.find_read, cmd.find_eval, cmd.commit}))
    else $error("conflicting commands");

endmodule

// ===== src/iou_dp.sv =====
module iou_dp #(
  parameter int MAX_TRACKS = iou_pkg::MAX_TRACKS_DEF,
  parameter int COORD_BITS = iou_pkg::COORD_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  iou_pkg::iou_cmd_t                     cmd,
  output iou_pkg::iou_sts_t                     sts,
  input  logic                                  thr_we,
  input  logic [iou_pkg::THR_W-1:0]             thr_data,
  input  logic signed [iou_pkg::BOX_COORD_W-1:0] box_left,
  input  logic signed [iou_pkg::BOX_COORD_W-1:0] box_top,
  input  logic [iou_pkg::BOX_SIZE_W-1:0]        box_width,
  input  logic [iou_pkg::BOX_SIZE_W-1:0]        box_height,
  output logic                                  result_valid,
  output logic [iou_pkg::ID_W-1:0]              track_id,
  output logic                                  matched_existing,
  output logic                                  table_full_drop
);
  import iou_pkg::*;

  localparam int AW  = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
  localparam int CW  = $clog2(MAX_TRACKS + 1);
  localparam int EW  = ID_W + 2 * COORD_BITS + 2 * BOX_SIZE_W;
  // Edge sums, signed: wide enough for a far edge plus a full size.
  localparam int PW  = ((COORD_BITS > BOX_SIZE_W) ? COORD_BITS : BOX_SIZE_W + 1) + 2;
  localparam int AR  = 2 * BOX_SIZE_W;             // area width
  localparam int UW  = AR + 2;                     // union width, signed
  localparam int XW  = UW + AR + 1;                // cross product width

  // Box register.
  logic signed [COORD_BITS-1:0] bl, bt;
  logic [BOX_SIZE_W-1:0]        bw, bh;
  logic [THR_W-1:0]             thr;

  // Banks and their valid bits.
  logic                  sel;
  logic [MAX_TRACKS-1:0] vld_a, vld_b;
  logic [AW-1:0]         idx;
  logic [CW-1:0]         cnt;
  logic [ID_W-1:0]       next_id;
  logic [EW-1:0]         rd_a, rd_b, wdata;
  logic                  we_a, we_b;
  logic [AW-1:0]         waddr;

  // Search state.
  logic                  found;
  logic [AR-1:0]         best_i;
  logic [UW-1:0]         best_u;
  logic [ID_W-1:0]       best_id;
  logic [ID_W-1:0]       dec_id;
  logic                  dec_match;
  logic                  hit;
  logic [AW-1:0]         hit_idx;

  iou_ram #(.WIDTH(EW), .DEPTH(MAX_TRACKS)) u_bank_a (
    .clk(clk), .we(we_a), .waddr(waddr), .wdata(wdata), .raddr(idx), .rdata(rd_a));
  iou_ram #(.WIDTH(EW), .DEPTH(MAX_TRACKS)) u_bank_b (
    .clk(clk), .we(we_b), .waddr(waddr), .wdata(wdata), .raddr(idx), .rdata(rd_b));

  // Previous table is the bank named by sel; current is the other.
  logic [EW-1:0] prev_e, cur_e;
  logic          prev_v, cur_v;
  assign prev_e = sel ? rd_b : rd_a;
  assign cur_e  = sel ? rd_a : rd_b;
  assign prev_v = sel ? vld_b[idx] : vld_a[idx];
  assign cur_v  = sel ? vld_a[idx] : vld_b[idx];

  // Unpack the previous entry.
  logic [ID_W-1:0]              e_id;
  logic signed [COORD_BITS-1:0] e_l, e_t;
  logic [BOX_SIZE_W-1:0]        e_w, e_h;
  assign {e_id, e_l, e_t, e_w, e_h} = prev_e;

  // Overlap of the entry and the box.
  logic signed [PW-1:0] x1, y1, x2, y2, er, eb, br, bb, dw, dh;
  logic [BOX_SIZE_W:0]  ow, oh;
  logic [AR-1:0]        inter, area_e, area_b;
  logic signed [UW-1:0] uni;
  always_comb begin
    x1 = (e_l > bl) ? PW'(e_l) : PW'(bl);
    y1 = (e_t > bt) ? PW'(e_t) : PW'(bt);
    er = PW'(e_l) + PW'($signed({1'b0, e_w}));
    eb = PW'(e_t) + PW'($signed({1'b0, e_h}));
    br = PW'(bl) + PW'($signed({1'b0, bw}));
    bb = PW'(bt) + PW'($signed({1'b0, bh}));
    x2 = (er < br) ? er : br;
    y2 = (eb < bb) ? eb : bb;
    dw = x2 - x1;
    dh = y2 - y1;
    ow = (dw > 0) ? dw[BOX_SIZE_W:0] : '0;
    oh = (dh > 0) ? dh[BOX_SIZE_W:0] : '0;
  end

  // Registered products, then compare the next cycle.
  logic [AR-1:0]        inter_r, area_e_r, area_b_r;
  logic [ID_W-1:0]      id_r;
  logic                 v_r;
  always_ff @(posedge clk) begin
    inter_r  <= AR'(ow * oh);
    area_e_r <= AR'(e_w * e_h);
    area_b_r <= AR'(bw * bh);
    id_r     <= e_id;
    v_r      <= prev_v;
  end
  assign inter  = inter_r;
  assign area_e = area_e_r;
  assign area_b = area_b_r;
  assign uni    = UW'(area_e) + UW'(area_b) - UW'(inter);

  // Cross-multiplied ratio compare.
  logic [XW-1:0] lhs, rhs;
  logic          better;
  assign lhs = XW'(inter) * XW'(best_u);
  assign rhs = XW'(best_i) * XW'(uni[UW-2:0]);
  assign better = v_r && (uni > 0) && (inter != '0) &&
                  ((lhs > rhs) || (found && lhs == rhs && id_r < best_id));

  // Threshold test of the best track.
  logic [XW-1:0] tl, tr;
  assign tl = XW'({best_i, 8'd0});
  assign tr = XW'(thr) * XW'(best_u);

  logic [ID_W-1:0] c_id;
  assign c_id = cur_e[EW-1 -: ID_W];

  assign sts.scan_last = (idx == AW'(MAX_TRACKS - 1));
  assign sts.find_last = (idx == AW'(MAX_TRACKS - 1));
  assign sts.find_hit  = cur_v && (c_id == dec_id);

  logic do_write;
  assign do_write = cmd.commit && (hit || cnt < CW'(MAX_TRACKS));
  assign waddr    = hit ? hit_idx : cnt[AW-1:0];
  assign wdata    = {dec_id, bl, bt, bw, bh};
  assign we_a     = do_write && sel;
  assign we_b     = do_write && !sel;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr     <= THR_RESET;
      sel     <= 1'b0;
      vld_a   <= '0;
      vld_b   <= '0;
      next_id <= '0;
      cnt     <= '0;
      idx     <= '0;
      result_valid <= 1'b0;
    end else begin
      if (thr_we) begin
        thr <= thr_data;
      end
      if (cmd.load_box) begin
        bl <= COORD_BITS'(box_left);
        bt <= COORD_BITS'(box_top);
        bw <= box_width;
        bh <= box_height;
        idx <= '0;
        found <= 1'b0;
        best_i <= '0;
        best_u <= UW'(1);
        best_id <= '0;
        hit <= 1'b0;
      end
      if (cmd.scan_eval) begin
        if (better) begin
          best_i  <= inter;
          best_u  <= uni;
          best_id <= id_r;
          found   <= 1'b1;
        end
        idx <= idx + AW'(1);
      end
      if (cmd.decide) begin
        idx <= '0;
        if (found && tl > tr) begin
          dec_id    <= best_id;
          dec_match <= 1'b1;
        end else begin
          dec_id    <= next_id;
          dec_match <= 1'b0;
          next_id   <= next_id + ID_W'(1);
        end
      end
      if (cmd.find_eval) begin
        if (sts.find_hit) begin
          hit     <= 1'b1;
          hit_idx <= idx;
        end else begin
          idx <= idx + AW'(1);
        end
      end
      if (cmd.commit) begin
        if (!hit && cnt < CW'(MAX_TRACKS) && !cmd.swap) begin
          cnt <= cnt + CW'(1);
        end
        if (do_write && sel) begin
          vld_a[waddr] <= 1'b1;
        end
        if (do_write && !sel) begin
          vld_b[waddr] <= 1'b1;
        end
        result_valid     <= 1'b1;
        track_id         <= dec_id;
        matched_existing <= dec_match;
        table_full_drop  <= !do_write;
      end
      if (cmd.close_only) begin
        result_valid     <= 1'b0;
        track_id         <= '0;
        matched_existing <= 1'b0;
        table_full_drop  <= 1'b0;
      end
      // Frame end: the old previous table is emptied and becomes current.
      if (cmd.swap) begin
        sel <= !sel;
        cnt <= '0;
        if (sel) begin
          vld_b <= '0;
        end else begin
          vld_a <= '0;
        end
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(MAX_TRACKS))
    else $error("fill count overflow");
  assert property (@(posedge clk) disable iff (rst)
    cmd.swap |=> (cnt == '0))
    else $error("count not cleared at frame end");
  assert property (@(posedge clk) disable iff (rst)
    cmd.swap |=> (sel != $past(sel)))
    else $error("bank select did not toggle");

endmodule

// ===== src/iou_track_id_assigner_unit.sv =====
// A box passes through a serial scan of the previous table, each entry taking a RAM
// read, registered products and a compare, and then the id search of the current
// table, a read and an id compare per entry. A frame-close-only beat is answered
// directly from idle. One beat is in flight at a time; the next beat is taken
// the cycle after the result beat leaves.
// Reset (rst, synchronous): tables empty, ids restart at zero, threshold 128.
module iou_track_id_assigner_unit #(
  parameter int MAX_TRACKS = iou_pkg::MAX_TRACKS_DEF,
  parameter int COORD_BITS = iou_pkg::COORD_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [iou_pkg::THR_W-1:0]              match_threshold,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [iou_pkg::BOX_COORD_W-1:0] box_left,
  input  logic signed [iou_pkg::BOX_COORD_W-1:0] box_top,
  input  logic [iou_pkg::BOX_SIZE_W-1:0]         box_width,
  input  logic [iou_pkg::BOX_SIZE_W-1:0]         box_height,
  input  logic                                   no_detection,
  input  logic                                   frame_last,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic                                   result_valid,
  output logic [iou_pkg::ID_W-1:0]               track_id,
  output logic                                   matched_existing,
  output logic                                   table_full_drop
);
  import iou_pkg::*;

  iou_cmd_t cmd;
  iou_sts_t sts;

  assign cfg_ready = 1'b1;

  iou_ctrl u_ctrl (
    .clk(clk), .rst(rst), .box_valid(in_valid), .box_ready(in_ready),
    .no_detection(no_detection), .frame_last(frame_last),
    .out_valid(out_valid), .out_ready(out_ready), .sts(sts), .cmd(cmd));

  iou_dp #(.MAX_TRACKS(MAX_TRACKS), .COORD_BITS(COORD_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .thr_we(cfg_valid), .thr_data(match_threshold),
    .box_left(box_left), .box_top(box_top),
    .box_width(box_width), .box_height(box_height),
    .result_valid(result_valid), .track_id(track_id),
    .matched_existing(matched_existing), .table_full_drop(table_full_drop));

endmodule
